// ===== src/assert_macros.svh =====
// Shared assertion helpers, clocked on clk_i, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define VNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition implies a consequence on the next cycle.
`define VNS_ASSERT_NXT(lbl, pre, post, msg) \
  `VNS_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== src/vns_pkg.sv =====
package vns_pkg;

  localparam int IdxW  = 10;
  localparam int PosW  = 32;
  localparam int NrmW  = 16;
  localparam int AccW  = 24;
  localparam int EdW   = 31;
  localparam int CrW   = 62;
  localparam int QDepth = 2;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_TRI  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_TRI,
    OP_READ,
    OP_READ_BAD
  } op_e;

  typedef logic signed [CrW-1:0]  wide_t;
  typedef logic signed [NrmW-1:0] nrm_t;

  typedef struct packed {
    op_e                   op;
    logic [IdxW-1:0]       a;
    logic [IdxW-1:0]       b;
    logic [IdxW-1:0]       c;
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic signed [PosW-1:0] pz;
    nrm_t                  nx;
    nrm_t                  ny;
    nrm_t                  nz;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic deg;
  } norm_stat_t;

endpackage

// ===== src/vns_front.sv =====
module vns_front #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // idx[9:0] pos_x[41:10] pos_y[73:42] pos_z[105:74] init_nx[121:106]
  // init_ny[137:122] init_nz[153:138] corner_b[163:154] corner_c[173:164]
  input  logic [175:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]    s_axis_tuser,
  input  logic          q_full_i,
  output logic          q_push_o,
  output vns_pkg::cmd_t q_cmd_o
);
  import vns_pkg::*;

  logic accept, keep, a_ok, b_ok, c_ok;
  logic [IdxW-1:0] ia, ib, ic;

  assign s_axis_tready = !q_full_i && rst_ni;
  assign accept = s_axis_tvalid && s_axis_tready;

  assign ia = s_axis_tdata[9:0];
  assign ib = s_axis_tdata[163:154];
  assign ic = s_axis_tdata[173:164];
  assign a_ok = 32'(ia) < MAX_VERTICES;
  assign b_ok = 32'(ib) < MAX_VERTICES;
  assign c_ok = 32'(ic) < MAX_VERTICES;

  always_comb begin
    q_cmd_o.a  = ia;
    q_cmd_o.b  = ib;
    q_cmd_o.c  = ic;
    q_cmd_o.px = s_axis_tdata[41:10];
    q_cmd_o.py = s_axis_tdata[73:42];
    q_cmd_o.pz = s_axis_tdata[105:74];
    q_cmd_o.nx = s_axis_tdata[121:106];
    q_cmd_o.ny = s_axis_tdata[137:122];
    q_cmd_o.nz = s_axis_tdata[153:138];
    q_cmd_o.op = OP_LOAD;
    keep = 1'b0;
    case (s_axis_tuser)
      KIND_LOAD: begin
        keep = a_ok;
      end
      KIND_TRI: begin
        q_cmd_o.op = OP_TRI;
        keep = a_ok && b_ok && c_ok;
      end
      KIND_READ: begin
        q_cmd_o.op = a_ok ? OP_READ : OP_READ_BAD;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push_o = accept && keep;

endmodule

// ===== src/vns_fifo.sv =====
module vns_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vns_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output vns_pkg::cmd_t head_o
);
  import vns_pkg::*;

  localparam int PtrW = $clog2(QDepth);

  cmd_t            mem_q [QDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = cnt_q == (PtrW+1)'(QDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PtrW'(QDepth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PtrW'(QDepth - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

// ===== src/vns_norm.sv =====
module vns_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  vns_pkg::wide_t      v_i [3],
  output vns_pkg::nrm_t       n_o [3],
  output vns_pkg::norm_stat_t stat_o
);
  import vns_pkg::*;

  typedef enum logic [2:0] {
    N_IDLE,
    N_CHK,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DINIT,
    N_DIV
  } nstate_e;

  nstate_e     state_q;
  logic [CrW-1:0] m_q [3];
  logic [2:0]  sg_q;
  logic [CrW-1:0] m_or;
  logic [59:0] prod_q;
  logic [61:0] x_q;
  logic [62:0] r_q, bit_q;
  logic [63:0] t;
  logic [4:0]  cnt_q;
  logic [1:0]  ci_q;
  logic [44:0] rem_q, den_q;
  logic [14:0] qt_q, qn;
  logic [30:0] len;
  logic        done_q, deg_q;
  nrm_t        n_q [3];

  assign m_or = m_q[0] | m_q[1] | m_q[2];
  assign t    = {1'b0, r_q} + {1'b0, bit_q};
  assign len  = r_q[30:0];
  assign qn   = {qt_q[13:0], rem_q >= den_q};

  assign n_o = n_q;
  assign stat_o.busy = state_q != N_IDLE;
  assign stat_o.done = done_q;
  assign stat_o.deg  = deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      deg_q   <= 1'b0;
      cnt_q   <= '0;
      ci_q    <= '0;
    end else begin
      case (state_q)
        N_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            for (int i = 0; i < 3; i++) begin
              sg_q[i] <= v_i[i][CrW-1];
              m_q[i]  <= v_i[i][CrW-1] ? CrW'(-v_i[i]) : CrW'(v_i[i]);
            end
            state_q <= N_CHK;
          end
        end
        N_CHK: begin
          if (m_or == '0) begin
            for (int i = 0; i < 3; i++) n_q[i] <= '0;
            deg_q   <= 1'b1;
            done_q  <= 1'b1;
            state_q <= N_IDLE;
          end else begin
            deg_q   <= 1'b0;
            state_q <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (|m_or[CrW-1:30]) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
          end else if (!m_or[29]) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
          end else begin
            x_q     <= '0;
            cnt_q   <= '0;
            state_q <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt_q < 5'd3) begin
            prod_q <= m_q[cnt_q[1:0]][29:0] * m_q[cnt_q[1:0]][29:0];
          end
          if (cnt_q != '0) begin
            x_q <= x_q + 62'(prod_q);
          end
          if (cnt_q == 5'd3) begin
            r_q     <= '0;
            bit_q   <= 63'(1) << 62;
            cnt_q   <= '0;
            state_q <= N_SQRT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        N_SQRT: begin
          if ({2'b0, x_q} >= t) begin
            x_q <= 62'({2'b0, x_q} - t);
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'd31) begin
            ci_q    <= '0;
            state_q <= N_DINIT;
          end
        end
        N_DINIT: begin
          rem_q   <= {1'b0, m_q[ci_q][29:0], 14'b0} + 45'(len >> 1);
          den_q   <= {len, 14'b0};
          qt_q    <= '0;
          cnt_q   <= '0;
          state_q <= N_DIV;
        end
        N_DIV: begin
          if (rem_q >= den_q) begin
            rem_q <= rem_q - den_q;
          end
          den_q <= den_q >> 1;
          qt_q  <= qn;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'd14) begin
            n_q[ci_q] <= sg_q[ci_q] ? -nrm_t'({1'b0, qn}) : nrm_t'({1'b0, qn});
            if (ci_q == 2'd2) begin
              done_q  <= 1'b1;
              state_q <= N_IDLE;
            end else begin
              ci_q    <= ci_q + 1'b1;
              state_q <= N_DINIT;
            end
          end
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

endmodule

// ===== src/vns_back.sv =====
`include "assert_macros.svh"
module vns_back #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  vns_pkg::cmd_t q_head_i,
  output logic          q_pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // out_index[9:0] norm_x[25:10] norm_y[41:26] norm_z[57:42]
  output logic [63:0]   m_axis_tdata,
  // degenerate[0]
  output logic          m_axis_tuser
);
  import vns_pkg::*;

  localparam int Depth = (MAX_VERTICES < (1 << IdxW)) ? MAX_VERTICES : (1 << IdxW);
  localparam int AW    = $clog2(Depth);
  localparam logic signed [AccW:0] AccMax = (AccW+1)'((1 << (AccW - 1)) - 1);
  localparam logic signed [AccW:0] AccMin = -(AccW+1)'(1 << (AccW - 1));

  typedef enum logic [3:0] {
    S_IDLE,
    S_TB,
    S_TC,
    S_EDGE,
    S_SHRINK,
    S_MUL,
    S_NSTART,
    S_NWAIT,
    S_ACC_RD,
    S_ACC_WR,
    S_RSTART,
    S_RWAIT,
    S_RESULT
  } state_e;

  state_e state_q;
  cmd_t   cmd_q;

  logic [3*PosW-1:0] pos_mem [Depth];
  logic [3*AccW-1:0] acc_mem [Depth];
  logic [3*PosW-1:0] pos_rdata_q;
  logic [3*AccW-1:0] acc_rdata_q;
  logic [AW-1:0]     pos_raddr, acc_raddr, acc_waddr;
  logic              pos_we, acc_we;
  logic [3*AccW-1:0] acc_wdata;

  logic signed [PosW-1:0] pa_q [3], pb_q [3];
  logic signed [PosW:0]   e0r_q [3], e1r_q [3];
  logic signed [EdW-1:0]  e0_q [3], e1_q [3], e0_d [3], e1_d [3];
  logic signed [EdW-1:0]  opa, opb;
  logic signed [CrW-1:0]  prod, prod_q;
  wide_t                  cr_q [3], nv [3];
  logic [2:0]             cnt_q, jj;
  logic [1:0]             k_q;
  logic [IdxW-1:0]        corner;

  logic                   norm_start;
  nrm_t                   nn [3];
  norm_stat_t             norm_st;

  logic                   out_deg_q;
  logic [IdxW-1:0]        out_idx_q;
  nrm_t                   out_n_q [3];

  function automatic logic [PosW:0] mag33(logic signed [PosW:0] v);
    return v[PosW] ? (PosW+1)'(-v) : (PosW+1)'(v);
  endfunction

  function automatic void shrink(input logic signed [PosW:0] e [3],
                                 output logic signed [EdW-1:0] o [3]);
    logic [PosW:0] m [3];
    logic [PosW:0] mo;
    logic [1:0]    s;
    logic [PosW:0] q;
    for (int i = 0; i < 3; i++) m[i] = mag33(e[i]);
    mo = m[0] | m[1] | m[2];
    s = mo[32] ? 2'd3 : mo[31] ? 2'd2 : mo[30] ? 2'd1 : 2'd0;
    for (int i = 0; i < 3; i++) begin
      q = m[i] >> s;
      o[i] = e[i][PosW] ? -EdW'(q) : EdW'(q);
    end
  endfunction

  function automatic logic [AccW-1:0] sat_add(logic [AccW-1:0] a, nrm_t f);
    logic signed [AccW:0] s;
    s = $signed({a[AccW-1], a}) + (AccW+1)'(f);
    if (s > AccMax) return AccMax[AccW-1:0];
    if (s < AccMin) return AccMin[AccW-1:0];
    return s[AccW-1:0];
  endfunction

  always_comb begin
    shrink(e0r_q, e0_d);
    shrink(e1r_q, e1_d);
  end

  // cross product terms, one per cycle
  always_comb begin
    case (cnt_q)
      3'd0: begin opa = e0_q[1]; opb = e1_q[2]; end
      3'd1: begin opa = e0_q[2]; opb = e1_q[1]; end
      3'd2: begin opa = e0_q[2]; opb = e1_q[0]; end
      3'd3: begin opa = e0_q[0]; opb = e1_q[2]; end
      3'd4: begin opa = e0_q[0]; opb = e1_q[1]; end
      3'd5: begin opa = e0_q[1]; opb = e1_q[0]; end
      default: begin opa = '0; opb = '0; end
    endcase
  end
  assign prod = opa * opb;
  assign jj   = cnt_q - 3'd1;

  always_comb begin
    case (k_q)
      2'd0:    corner = cmd_q.a;
      2'd1:    corner = cmd_q.b;
      default: corner = cmd_q.c;
    endcase
  end

  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;

  always_comb begin
    pos_raddr = q_head_i.a[AW-1:0];
    acc_raddr = q_head_i.a[AW-1:0];
    case (state_q)
      S_TB:     pos_raddr = cmd_q.b[AW-1:0];
      S_TC:     pos_raddr = cmd_q.c[AW-1:0];
      S_ACC_RD: acc_raddr = corner[AW-1:0];
      default:  ;
    endcase
  end

  assign pos_we = q_pop_o && (q_head_i.op == OP_LOAD);

  always_comb begin
    acc_we    = pos_we;
    acc_waddr = q_head_i.a[AW-1:0];
    acc_wdata = {AccW'(q_head_i.nz), AccW'(q_head_i.ny), AccW'(q_head_i.nx)};
    if (state_q == S_ACC_WR) begin
      acc_we    = 1'b1;
      acc_waddr = corner[AW-1:0];
      for (int i = 0; i < 3; i++) begin
        acc_wdata[i*AccW +: AccW] = sat_add(acc_rdata_q[i*AccW +: AccW], nn[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[q_head_i.a[AW-1:0]] <= {q_head_i.pz, q_head_i.py, q_head_i.px};
    end
    pos_rdata_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_rdata_q <= acc_mem[acc_raddr];
  end

  assign norm_start = (state_q == S_NSTART) || (state_q == S_RSTART);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv[i] = (state_q == S_RSTART) ? CrW'($signed(acc_rdata_q[i*AccW +: AccW]))
                                    : cr_q[i];
    end
  end

  vns_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .v_i     (nv),
    .n_o     (nn),
    .stat_o  (norm_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      cnt_q         <= '0;
      k_q           <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state_q != S_RESULT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            cmd_q <= q_head_i;
            case (q_head_i.op)
              OP_TRI:      state_q <= S_TB;
              OP_READ:     state_q <= S_RSTART;
              OP_READ_BAD: state_q <= S_RESULT;
              default:     state_q <= S_IDLE;
            endcase
          end
        end
        S_TB: begin
          for (int i = 0; i < 3; i++) pa_q[i] <= pos_rdata_q[i*PosW +: PosW];
          state_q <= S_TC;
        end
        S_TC: begin
          for (int i = 0; i < 3; i++) pb_q[i] <= pos_rdata_q[i*PosW +: PosW];
          state_q <= S_EDGE;
        end
        S_EDGE: begin
          for (int i = 0; i < 3; i++) begin
            e0r_q[i] <= (PosW+1)'(pb_q[i]) - (PosW+1)'(pa_q[i]);
            e1r_q[i] <= (PosW+1)'($signed(pos_rdata_q[i*PosW +: PosW]))
                        - (PosW+1)'(pa_q[i]);
          end
          state_q <= S_SHRINK;
        end
        S_SHRINK: begin
          e0_q    <= e0_d;
          e1_q    <= e1_d;
          cnt_q   <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (cnt_q < 3'd6) begin
            prod_q <= prod;
          end
          if (cnt_q != '0) begin
            if (!jj[0]) cr_q[jj[2:1]] <= prod_q;
            else        cr_q[jj[2:1]] <= cr_q[jj[2:1]] - prod_q;
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 3'd6) begin
            state_q <= S_NSTART;
          end
        end
        S_NSTART: state_q <= S_NWAIT;
        S_NWAIT: begin
          if (norm_st.done) begin
            k_q     <= '0;
            state_q <= S_ACC_RD;
          end
        end
        S_ACC_RD: state_q <= S_ACC_WR;
        S_ACC_WR: begin
          k_q     <= k_q + 1'b1;
          state_q <= (k_q == 2'd2) ? S_IDLE : S_ACC_RD;
        end
        S_RSTART: state_q <= S_RWAIT;
        S_RWAIT: begin
          if (norm_st.done) begin
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_idx_q     <= cmd_q.a;
            if (cmd_q.op == OP_READ_BAD) begin
              out_deg_q <= 1'b1;
              for (int i = 0; i < 3; i++) out_n_q[i] <= '0;
            end else begin
              out_deg_q <= norm_st.deg;
              out_n_q   <= nn;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {6'b0, out_n_q[2], out_n_q[1], out_n_q[0], out_idx_q};
  assign m_axis_tuser = out_deg_q;

  `VNS_ASSERT(a_norm_idle, norm_start |-> !norm_st.busy, "normalizer started while busy")
  `VNS_ASSERT_NXT(a_norm_run, state_q == S_NSTART, norm_st.busy, "normalizer did not start")
  `VNS_ASSERT(a_done_wait, norm_st.done |-> (state_q == S_NWAIT || state_q == S_RWAIT), "normalizer result with nobody waiting")
  `VNS_ASSERT(a_rmw_addr, (state_q == S_ACC_WR) |-> (acc_waddr == $past(acc_raddr)), "accumulator write address differs from read")

endmodule

// ===== src/vertex_normal_smoothing_core.sv =====
// Vertex normal smoothing. Load words store a vertex position and its
// initial normal, triangle words add the unit face normal to each corner's
// accumulator, read words return the normalized accumulator of one vertex.
// Words are classified at the input and queued (two entries) ahead of the
// execution side, so the input keeps taking words while the back is busy
// until the queue is full. A load is written from the queue head while the
// back is idle. A zero vector skips the square root and the divides, and an
// out-of-range read goes straight to the result. The normalizer dominates,
// with a one-bit-a-cycle alignment shift, a serial square root and three
// 15-bit serial divides. A triangle adds three position reads, a shared
// cross-product multiplier and three accumulator read-modify-writes.
// Memories are not cleared; reading a vertex never loaded returns garbage.
module vertex_normal_smoothing_core #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vertex_index[9:0] pos_x[41:10] pos_y[73:42] pos_z[105:74] init_nx[121:106]
  // init_ny[137:122] init_nz[153:138] corner_b[163:154] corner_c[173:164]
  input  logic [175:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_index[9:0] norm_x[25:10] norm_y[41:26] norm_z[57:42]
  output logic [63:0]  m_axis_tdata,
  // degenerate[0]
  output logic         m_axis_tuser
);
  import vns_pkg::*;

  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_cmd, q_head;

  vns_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_cmd)
  );

  vns_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  vns_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import vns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NVtx = 1024;
  localparam int CycleLimit = 1000000;
  localparam int Settle = 400;
  localparam int PoolSz = 16;
  localparam logic [1:0] KindBad = 2'd3;

  typedef struct {
    logic [9:0]         idx;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               deg;
  } nrm_word_t;

  class normal_scoreboard;
    longint    pos[NVtx][3];
    longint    acc[NVtx][3];
    nrm_word_t pending[$];
    int        n_err;
    int        n_checked;
    int        n_deg;

    function automatic longint unsigned magn(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic void shrink(ref longint e[3]);
      longint unsigned m[3], mx;
      int s;
      mx = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = magn(e[i]);
        if (m[i] > mx) mx = m[i];
      end
      while ((mx >> s) >= (64'd1 << 30)) s++;
      for (int i = 0; i < 3; i++)
        e[i] = e[i] < 0 ? -longint'(m[i] >> s) : longint'(m[i] >> s);
    endfunction

    // returns 1 for a zero-length vector
    function automatic bit unit_vec(input longint v[3], ref longint o[3]);
      longint unsigned m[3], mx, sum, len, q;
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = magn(v[i]);
        if (m[i] > mx) mx = m[i];
        o[i] = 0;
      end
      if (mx == 0) return 1;
      while (mx >= (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) m[i] >>= 1;
        mx >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        for (int i = 0; i < 3; i++) m[i] <<= 1;
        mx <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * 16384 + len / 2) / len;
        o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 0;
    endfunction

    function automatic longint sat24(longint a);
      if (a > 8388607) return 8388607;
      if (a < -8388608) return -8388608;
      return a;
    endfunction

    function automatic void note_word(logic [1:0] kind, logic [175:0] d);
      logic [9:0] c[3];
      longint e0[3], e1[3], cr[3], fn[3], n[3];
      nrm_word_t w;
      bit dg;
      c[0] = d[9:0];
      c[1] = d[163:154];
      c[2] = d[173:164];
      case (kind)
        KIND_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            pos[c[0]][i] = longint'($signed(d[10+32*i +: 32]));
            acc[c[0]][i] = longint'($signed(d[106+16*i +: 16]));
          end
        end
        KIND_TRI: begin
          for (int i = 0; i < 3; i++) begin
            e0[i] = pos[c[1]][i] - pos[c[0]][i];
            e1[i] = pos[c[2]][i] - pos[c[0]][i];
          end
          shrink(e0);
          shrink(e1);
          cr[0] = e0[1] * e1[2] - e0[2] * e1[1];
          cr[1] = e0[2] * e1[0] - e0[0] * e1[2];
          cr[2] = e0[0] * e1[1] - e0[1] * e1[0];
          void'(unit_vec(cr, fn));
          for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
              acc[c[k]][i] = sat24(acc[c[k]][i] + fn[i]);
        end
        KIND_READ: begin
          dg = unit_vec(acc[c[0]], n);
          w.idx = c[0];
          w.x = n[0][15:0];
          w.y = n[1][15:0];
          w.z = n[2][15:0];
          w.deg = dg;
          pending.push_back(w);
        end
        default: ;
      endcase
    endfunction

    function automatic void check_word(logic [63:0] d, logic u);
      nrm_word_t w;
      n_checked++;
      if (u) n_deg++;
      if (pending.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected word idx=%0d", d[9:0]);
        return;
      end
      w = pending.pop_front();
      if (d[9:0] !== w.idx || d[25:10] !== w.x || d[41:26] !== w.y ||
          d[57:42] !== w.z || u !== w.deg) begin
        n_err++;
        if (n_err <= 10)
          $display("mismatch exp idx=%0d n=(%0d,%0d,%0d) deg=%0b got idx=%0d n=(%0d,%0d,%0d) deg=%0b",
                   w.idx, w.x, w.y, w.z, w.deg, d[9:0], $signed(d[25:10]),
                   $signed(d[41:26]), $signed(d[57:42]), u);
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;

  normal_scoreboard sb = new();
  bit   quiet = 0;
  int   cycles = 0;
  int   n_load = 0, n_tri = 0, n_read = 0;
  logic [9:0] pool[PoolSz];

  vertex_normal_smoothing_core dut (.*);

  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        m_axis_tready = 0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready = 1;
    end
  end

  task automatic put_word(logic [1:0] kind, logic [9:0] a, int px, int py, int pz,
                          int nx, int ny, int nz,
                          logic [9:0] b, logic [9:0] c);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tuser = kind;
    s_axis_tdata = {2'b00, c, b, nz[15:0], ny[15:0], nx[15:0], pz, py, px, a};
    s_axis_tvalid = 1;
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_word(kind, s_axis_tdata);
    case (kind)
      KIND_LOAD: n_load++;
      KIND_TRI:  n_tri++;
      KIND_READ: n_read++;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  function automatic int rnd_pos();
    case ($urandom_range(0, 3))
      0: return int'($urandom);
      1: return 0;
      default: return int'($urandom_range(0, 2097152)) - 1048576;
    endcase
  endfunction

  function automatic int rnd_nrm();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  task automatic load_rnd(logic [9:0] a);
    put_word(KIND_LOAD, a, rnd_pos(), rnd_pos(), rnd_pos(), rnd_nrm(), rnd_nrm(),
             rnd_nrm(), 10'($urandom), 10'($urandom));
  endtask

  task automatic op_rnd(logic [1:0] kind, logic [9:0] a, logic [9:0] b, logic [9:0] c);
    put_word(kind, a, int'($urandom), int'($urandom), int'($urandom), int'($urandom),
             int'($urandom), int'($urandom), b, c);
  endtask

  initial begin
    int r;
    int j;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed
    put_word(KIND_LOAD, 10'd0, 0, 0, 0, 16384, 0, 0, 10'd0, 10'd0);
    put_word(KIND_LOAD, 10'd1, 32'h7fffffff, 0, 0, -16384, -16384, -16384, 10'd0, 10'd0);
    put_word(KIND_LOAD, 10'd1023, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 10'd0, 10'd0);
    op_rnd(KIND_TRI, 10'd0, 10'd1, 10'd1023);
    op_rnd(KIND_READ, 10'd0, 10'd0, 10'd0);
    op_rnd(KIND_READ, 10'd1, 10'd0, 10'd0);
    op_rnd(KIND_READ, 10'd1023, 10'd0, 10'd0);
    put_word(KIND_LOAD, 10'd2, 0, 32'h10000, 0, 0, 0, 0, 10'd0, 10'd0);
    op_rnd(KIND_READ, 10'd2, 10'd0, 10'd0);
    op_rnd(KIND_TRI, 10'd2, 10'd2, 10'd0);
    op_rnd(KIND_TRI, 10'd0, 10'd1, 10'd2);
    op_rnd(KIND_TRI, 10'd0, 10'd2, 10'd1);
    op_rnd(KIND_READ, 10'd2, 10'd0, 10'd0);
    op_rnd(KindBad, 10'($urandom), 10'($urandom), 10'($urandom));
    put_word(KIND_LOAD, 10'd3, 32'h10000, 0, 0, 0, 16384, -16384, 10'd0, 10'd0);
    op_rnd(KIND_TRI, 10'd0, 10'd3, 10'd2);
    op_rnd(KIND_TRI, 10'd3, 10'd3, 10'd3);
    op_rnd(KIND_READ, 10'd3, 10'd0, 10'd0);
    op_rnd(KIND_READ, 10'd0, 10'd0, 10'd0);

    // random, triangles over a small vertex pool so accumulators saturate
    for (int i = 0; i < PoolSz; i++) begin
      pool[i] = 10'($urandom);
      load_rnd(pool[i]);
    end
    for (int i = 0; i < 1400; i++) begin
      if (i > 1200) quiet = 1;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        j = $urandom_range(0, PoolSz-1);
        if ($urandom_range(0, 1)) pool[j] = 10'($urandom);
        load_rnd(pool[j]);
      end else if (r < 60) begin
        op_rnd(KIND_TRI, pool[$urandom_range(0, PoolSz-1)],
               pool[$urandom_range(0, PoolSz-1)], pool[$urandom_range(0, PoolSz-1)]);
      end else if (r < 97) begin
        op_rnd(KIND_READ, pool[$urandom_range(0, PoolSz-1)], 10'($urandom),
               10'($urandom));
      end else begin
        op_rnd(KindBad, 10'($urandom), 10'($urandom), 10'($urandom));
      end
    end
    s_axis_tvalid = 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    $display("tb: %0d loads, %0d triangles, %0d reads sent", n_load, n_tri, n_read);
    $display("tb: %0d normals checked (%0d degenerate), %0d mismatches",
             sb.n_checked, sb.n_deg, sb.n_err);
    if (sb.n_err == 0 && sb.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
